[rtl/lcfb_pkg.sv]
// Shared types, frame constants and the CRC-16 update function for the frame builder.
package lcfb_pkg;

	localparam int unsigned FrameLen = 13;
	localparam int unsigned IdxW     = $clog2(FrameLen);

	localparam logic [7:0] FLAG_BYTE  = 8'h7E;
	localparam logic [7:0] CTRL_BYTE  = 8'h01;
	localparam logic [7:0] ZERO_BYTE  = 8'h00;
	localparam logic [7:0] LEN_BYTE   = 8'h02;
	localparam logic [3:0] NIB_MASK   = 4'h0f;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CRC_INIT  = 16'h0000;

	// Byte positions within the frame.
	localparam logic [IdxW-1:0] POS_OPEN    = IdxW'(0);
	localparam logic [IdxW-1:0] POS_ADDR    = IdxW'(1);
	localparam logic [IdxW-1:0] POS_CTRL    = IdxW'(2);
	localparam logic [IdxW-1:0] POS_PAD0    = IdxW'(3);
	localparam logic [IdxW-1:0] POS_PAD1    = IdxW'(4);
	localparam logic [IdxW-1:0] POS_PAD2    = IdxW'(5);
	localparam logic [IdxW-1:0] POS_LEN     = IdxW'(6);
	localparam logic [IdxW-1:0] POS_CMD_HI  = IdxW'(7);
	localparam logic [IdxW-1:0] POS_CMD_LO  = IdxW'(8);
	localparam logic [IdxW-1:0] POS_CRC_HI  = IdxW'(9);
	localparam logic [IdxW-1:0] POS_CRC_LO  = IdxW'(10);
	localparam logic [IdxW-1:0] POS_CLOSE0  = IdxW'(11);
	localparam logic [IdxW-1:0] POS_CLOSE1  = IdxW'(12);

	typedef struct packed {
		logic [7:0]  device_addr;
		logic [15:0] command;
	} item_t;

	// Handshake between the input register and the serializer.
	typedef struct packed {
		logic  valid;
		item_t item;
	} in_stage_t;

	// Nibble table: entry n is the remainder of n placed in the top nibble.
	function automatic logic [15:0] crc_nib_tab(input logic [3:0] n);
		logic [15:0] v;
		v = {n, 12'h000};
		for (int k = 0; k < 4; k++) begin
			if (v[15]) begin
				v = {v[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[14:0], 1'b0};
			end
		end
		return v;
	endfunction

	// One byte of CRC-16/XMODEM, high nibble first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = {crc[11:0], 4'h0} ^ crc_nib_tab(crc[15:12] ^ b[7:4]);
		c = {c[11:0], 4'h0} ^ crc_nib_tab(c[15:12] ^ (b[3:0] & NIB_MASK));
		return c;
	endfunction

endpackage

[rtl/lcfb_in_reg.sv]
// Input holding register that takes the next command while a frame is being sent.
module lcfb_in_reg
	import lcfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       in_item,
	input  logic        take,
	output in_stage_t   stage
);

	logic  valid_s1;
	item_t item_s1;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

endmodule

[rtl/lcfb_serializer.sv]
// Frame serializer with a running CRC and the output register.
module lcfb_serializer
	import lcfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  in_stage_t   stage,
	output logic        take,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        last
);

	logic            active_q;
	logic [IdxW-1:0] idx_q;
	item_t           item_q;
	logic [15:0]     crc_q;
	logic            out_valid_q;
	logic [7:0]      byte_q;
	logic            last_q;

	logic            adv;
	logic [7:0]      cur_byte;
	logic            in_crc;

	assign adv  = !out_valid_q || out_ready;
	assign take = adv && !active_q && stage.valid;

	always_comb begin
		case (idx_q)
			POS_OPEN:   cur_byte = FLAG_BYTE;
			POS_ADDR:   cur_byte = item_q.device_addr;
			POS_CTRL:   cur_byte = CTRL_BYTE;
			POS_PAD0:   cur_byte = ZERO_BYTE;
			POS_PAD1:   cur_byte = ZERO_BYTE;
			POS_PAD2:   cur_byte = ZERO_BYTE;
			POS_LEN:    cur_byte = LEN_BYTE;
			POS_CMD_HI: cur_byte = item_q.command[15:8];
			POS_CMD_LO: cur_byte = item_q.command[7:0];
			POS_CRC_HI: cur_byte = crc_q[15:8];
			POS_CRC_LO: cur_byte = crc_q[7:0];
			POS_CLOSE0: cur_byte = FLAG_BYTE;
			POS_CLOSE1: cur_byte = FLAG_BYTE;
			default:    cur_byte = FLAG_BYTE;
		endcase
	end

	// The check covers the address through the command low byte.
	assign in_crc = (idx_q >= POS_ADDR) && (idx_q <= POS_CMD_LO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= POS_OPEN;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (active_q) begin
				out_valid_q <= 1'b1;
				if (idx_q == POS_CLOSE1) begin
					active_q <= 1'b0;
					idx_q    <= POS_OPEN;
				end else begin
					idx_q <= idx_q + IdxW'(1);
				end
			end else if (stage.valid) begin
				out_valid_q <= 1'b1;
				active_q    <= 1'b1;
				idx_q       <= POS_ADDR;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (active_q) begin
				byte_q <= cur_byte;
				last_q <= (idx_q == POS_CLOSE1);
				if (in_crc) begin
					crc_q <= crc_byte(crc_q, cur_byte);
				end
			end else if (stage.valid) begin
				byte_q <= FLAG_BYTE;
				last_q <= 1'b0;
				item_q <= stage.item;
				crc_q  <= CRC_INIT;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last       = last_q;

endmodule

[rtl/lock_command_frame_builder.sv]
// Top level of the lock command frame builder.
// Usage: the input channel (in_valid/in_ready) carries one command, made of
// device_addr and command. For each command transfer the block sends a
// 13-byte frame on the output channel (out_valid/out_ready) as frame_byte,
// one byte per transfer, with last high on the thirteenth byte. The frame is
// the opening flag, address, fixed header bytes, the command high byte first,
// the CRC-16/XMODEM over the address through the command low byte, and two
// closing flags.
// When the block is idle, an input transfer loads the input register, and the
// opening flag is then loaded into the output register. Frames go out through
// the single byte-wide output register; when the receiver does not stall, they
// follow each other with no gap, because the input register holds the next
// command while the current frame is still being sent. The CRC is accumulated
// one byte per cycle while the output is not stalled, as the payload bytes go
// out, so the check bytes are ready in time for their slots.
// Reset clears the valid flags and the frame position; no clearing pass is
// needed. When the receiver stalls, the output byte is held and the frame
// pauses; the input side then stops accepting once its register is full.
module lock_command_frame_builder
	import lcfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  device_addr,
	input  logic [15:0] command,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        last
);

	item_t     in_item;
	in_stage_t stage;
	logic      take;

	assign in_item.device_addr = device_addr;
	assign in_item.command     = command;

	// Holds the next command so it can be taken while a frame is in flight.
	lcfb_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (take),
		.stage    (stage)
	);

	// Steps through the frame positions and drives the output register.
	lcfb_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.stage      (stage),
		.take       (take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.last       (last)
	);

endmodule

[rtl/lcfb_checker.sv]
// Port-level checker for the frame builder and its bind to the top level.
module lcfb_checker
	import lcfb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  frame_byte,
	input logic        last
);

	logic [IdxW-1:0] pos_q;
	logic [1:0]      pend_q;
	logic            in_xfer;
	logic            out_xfer;
	logic            frame_done;

	assign in_xfer    = in_valid && in_ready;
	assign out_xfer   = out_valid && out_ready;
	assign frame_done = out_xfer && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_OPEN;
			pend_q <= 2'd0;
		end else begin
			if (out_xfer) begin
				pos_q <= last ? POS_OPEN : pos_q + IdxW'(1);
			end
			if (in_xfer && !frame_done) begin
				pend_q <= pend_q + 2'd1;
			end else if (!in_xfer && frame_done) begin
				pend_q <= pend_q - 2'd1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last))
		else $error("output changed while stalled");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (last == (pos_q == POS_CLOSE1)))
		else $error("last flag not on the thirteenth byte");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && (pos_q == POS_OPEN || pos_q == POS_CLOSE0 || pos_q == POS_CLOSE1)
		|-> frame_byte == FLAG_BYTE)
		else $error("flag byte missing");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("output without a pending command");

	// A full block frees a slot only as the current frame's last byte leaves.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 && !frame_done |-> !in_ready)
		else $error("command accepted with no room");

endmodule

bind lock_command_frame_builder lcfb_checker u_lcfb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.frame_byte  (frame_byte),
	.last        (last)
);

[tb/sv/tb_lock_command_frame_builder.sv]
// Self-checking testbench for the lock command frame builder, with a predicted 13-byte frame per command.
module tb_lock_command_frame_builder
	import lcfb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// One byte of the outgoing frame as it should appear on the output channel.
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last;
	} frame_entry_t;

	localparam int unsigned MaxIdle     = 12;
	localparam int unsigned RandomCmds  = 200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  device_addr;
	logic [15:0] command;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  frame_byte;
	logic        last;

	// Frame bytes that have been predicted but not yet seen on the output, oldest first.
	frame_entry_t pending_frame_bytes[$];

	int unsigned mismatch_count;
	int unsigned commands_sent;
	int unsigned bytes_checked;
	int unsigned frames_closed;

	// Idle controls: when cleared, that side never inserts gaps or stalls.
	bit sender_gaps_on;
	bit receiver_stalls_on;

	lock_command_frame_builder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.device_addr (device_addr),
		.command     (command),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_byte  (frame_byte),
		.last        (last)
	);

	always #4 clk = ~clk;

	// CRC-16/XMODEM, one byte at a time, processed bit by bit from the MSB.
	// This is deliberately a different formulation from the nibble-table
	// method in the design, so the two cross-check each other.
	function automatic logic [15:0] crc_xmodem_update(input logic [15:0] acc,
			input logic [7:0] data);
		logic [15:0] v;
		v = acc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (v[15]) begin
				v = {v[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[14:0], 1'b0};
			end
		end
		return v;
	endfunction

	// Build the full frame for one command and append it to the pending queue.
	// The CRC covers the address through the command low byte; flag bytes and
	// payload bytes that happen to equal the flag value are not escaped.
	function automatic void predict_command_frame(input logic [7:0] addr,
			input logic [15:0] cmd);
		logic [7:0]   fr[FrameLen];
		logic [15:0]  crc;
		frame_entry_t ent;
		fr[0]  = FLAG_BYTE;
		fr[1]  = addr;
		fr[2]  = CTRL_BYTE;
		fr[3]  = ZERO_BYTE;
		fr[4]  = ZERO_BYTE;
		fr[5]  = ZERO_BYTE;
		fr[6]  = LEN_BYTE;
		fr[7]  = cmd[15:8];
		fr[8]  = cmd[7:0];
		crc = CRC_INIT;
		for (int i = 1; i <= 8; i++) begin
			crc = crc_xmodem_update(crc, fr[i]);
		end
		fr[9]  = crc[15:8];
		fr[10] = crc[7:0];
		fr[11] = FLAG_BYTE;
		fr[12] = FLAG_BYTE;
		for (int i = 0; i < FrameLen; i++) begin
			ent.frame_byte = fr[i];
			ent.last       = (i == FrameLen - 1);
			pending_frame_bytes.push_back(ent);
		end
	endfunction

	// Count a failure; the caller reports the details.
	function automatic void note_failure();
		mismatch_count++;
	endfunction

	// Send one command. The task is entered and left at a rising edge. It
	// first idles for a random number of cycles (valid low), then raises
	// valid with the payload and holds both until the transfer. Valid is left
	// high on return so that a following command with no gap does not lower
	// and raise it within the same time step.
	task automatic send_command(input logic [7:0] addr, input logic [15:0] cmd);
		int unsigned gap;
		gap = sender_gaps_on ? $urandom_range(0, MaxIdle) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		device_addr <= addr;
		command     <= cmd;
		// Ready is judged at the falling edge, where everything driven or
		// updated at the rising edge has settled.
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		// The transfer happens at the coming rising edge; the first frame
		// byte cannot appear before then, so predicting now is safe.
		predict_command_frame(addr, cmd);
		commands_sent++;
		@(posedge clk);
	endtask

	// Drop valid and hold off until every predicted byte has been received.
	// A rising edge always passes after lowering valid so that a following send
	// never drives valid twice within one time step.
	task automatic hold_until_frames_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_frame_bytes.size() != 0) @(posedge clk);
	endtask

	// Random command code that leans toward interesting byte values now and then.
	function automatic logic [15:0] draw_command();
		logic [7:0] hi;
		logic [7:0] lo;
		hi = 8'($urandom_range(0, 255));
		lo = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0: hi = FLAG_BYTE;
			1: lo = FLAG_BYTE;
			2: hi = 8'hFF;
			3: lo = 8'h00;
			default: ;
		endcase
		return {hi, lo};
	endfunction

	// Address and command extremes, single set bits, and values that stress
	// the CRC's high bit feedback.
	task automatic test_field_extremes();
		sender_gaps_on     = 1'b1;
		receiver_stalls_on = 1'b1;
		send_command(8'h00, 16'h0000);
		send_command(8'hFF, 16'hFFFF);
		send_command(8'h00, 16'hFFFF);
		send_command(8'hFF, 16'h0000);
		send_command(8'h80, 16'h8000);
		send_command(8'h01, 16'h0001);
		send_command(8'hAA, 16'h5555);
		send_command(8'h55, 16'hAAAA);
		send_command(8'h12, 16'h3456);
	endtask

	// Payload bytes equal to the flag value must go out unescaped.
	task automatic test_flag_valued_payload();
		send_command(FLAG_BYTE, 16'h7E7E);
		send_command(FLAG_BYTE, 16'h0000);
		send_command(8'h00, {FLAG_BYTE, 8'h00});
		send_command(8'h00, {8'h00, FLAG_BYTE});
	endtask

	// Commands with no gaps and no stalls: frames should run back to back.
	task automatic test_back_to_back();
		sender_gaps_on     = 1'b0;
		receiver_stalls_on = 1'b0;
		for (int i = 0; i < 8; i++) begin
			send_command(8'($urandom_range(0, 255)), draw_command());
		end
		sender_gaps_on     = 1'b1;
		receiver_stalls_on = 1'b1;
	endtask

	// The sender stops until the block has fully emptied, then resumes, so
	// the first command after an idle block is exercised too.
	task automatic test_pause_until_drained();
		send_command(8'h3C, 16'hC3A5);
		send_command(8'hC3, 16'h5A3C);
		hold_until_frames_drained();
		send_command(8'h7F, 16'h7FFF);
		hold_until_frames_drained();
	endtask

	// Random commands in stretches; each stretch picks its own idle mix, so
	// some run with gaps on both sides, some with none at all, and at times
	// the sender stops until the block is empty.
	task automatic test_random_commands();
		for (int i = 0; i < RandomCmds; i++) begin
			if (i % 25 == 0) begin
				sender_gaps_on     = $urandom_range(0, 3) != 0;
				receiver_stalls_on = $urandom_range(0, 3) != 0;
			end
			if ($urandom_range(0, 49) == 0) begin
				hold_until_frames_drained();
			end
			send_command(8'($urandom_range(0, 255)), draw_command());
		end
	endtask

	// Receiver side. For every frame byte it draws a stall, keeps ready low
	// for that many cycles, then raises ready until a transfer is seen. Ready
	// changes only at rising edges and at most once per edge.
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = receiver_stalls_on ? $urandom_range(0, MaxIdle) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid) @(negedge clk);
			@(posedge clk);
		end
	end

	// Output checker. A transfer is recognized at the falling edge before the
	// rising edge that completes it, when valid, ready and the payload are all
	// stable. Each transfer is matched against the oldest predicted byte.
	always @(negedge clk) begin
		frame_entry_t exp_ent;
		if (arst_n && out_valid && out_ready) begin
			if (pending_frame_bytes.size() == 0) begin
				note_failure();
				$error("unexpected frame byte %02h (last=%0b) with nothing pending",
					frame_byte, last);
			end else begin
				exp_ent = pending_frame_bytes.pop_front();
				bytes_checked++;
				if (exp_ent.last) begin
					frames_closed++;
				end
				if (frame_byte !== exp_ent.frame_byte) begin
					note_failure();
					$error("frame_byte mismatch: expected %02h, got %02h",
						exp_ent.frame_byte, frame_byte);
				end
				if (last !== exp_ent.last) begin
					note_failure();
					$error("last mismatch: expected %0b, got %0b", exp_ent.last, last);
				end
			end
		end
	end

	// Main sequence: reset once, run each test in turn, drain, then report.
	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		device_addr        = '0;
		command            = '0;
		mismatch_count     = 0;
		commands_sent      = 0;
		bytes_checked      = 0;
		frames_closed      = 0;
		sender_gaps_on     = 1'b1;
		receiver_stalls_on = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_flag_valued_payload();
		test_back_to_back();
		test_pause_until_drained();
		test_random_commands();

		// Let the last frame finish, then wait on so that any stray byte after the
		// final expected one is caught.
		hold_until_frames_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d lock commands and checked %0d frame bytes in %0d frames,",
			commands_sent, bytes_checked, frames_closed);
		$display("with flag-valued payloads, field extremes, back-to-back and stalled traffic.");
		if (mismatch_count == 0 && pending_frame_bytes.size() == 0) begin
			$display("tb_lock_command_frame_builder passed");
		end else begin
			if (pending_frame_bytes.size() != 0) begin
				$error("%0d predicted frame bytes never arrived", pending_frame_bytes.size());
			end
			$display("tb_lock_command_frame_builder failed");
		end
		$finish;
	end

	// Watchdog: the slowest correct run is well under a millisecond.
	initial begin
		#5ms;
		$display("Timed out with %0d frame bytes still pending", pending_frame_bytes.size());
		$display("tb_lock_command_frame_builder failed");
		$finish;
	end

endmodule
